// ----- src/linear_chirp_sample_generator_core_assert.svh -----
// assertion helpers shared by the chirp generator modules
// every macro samples on clk and is quiet while rst_n is low
`ifndef LINEAR_CHIRP_SAMPLE_GENERATOR_CORE_ASSERT_SVH
`define LINEAR_CHIRP_SAMPLE_GENERATOR_CORE_ASSERT_SVH

// consequence must hold in the same cycle
`define LCSG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence must hold in the cycle after
`define LCSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lcsg_pkg.sv -----
package lcsg_pkg;

  localparam int PHASE_BITS_DEF      = 32;
  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int COUNT_BITS_DEF      = 24;

  localparam int AMP_W      = 15;
  localparam int STEP_W     = 32;
  localparam int COUNT_W    = 24;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int SAMPLE_W   = 16;
  localparam int ROM_W      = 15;
  localparam int FIFO_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_STEP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_INCREMENT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT   = 2'd3;

  localparam logic [1:0] QUAD_Q0 = 2'd0;
  localparam logic [1:0] QUAD_Q1 = 2'd1;
  localparam logic [1:0] QUAD_Q2 = 2'd2;
  localparam logic [1:0] QUAD_Q3 = 2'd3;

  // pi/2 in Q61
  localparam logic [63:0] HALF_PI_Q61 = 64'h3243F6A8885A308D;

  typedef struct packed {
    logic active;
    logic last;
    logic neg;
    logic zero;
  } flags_t;

  // (a * b) >> 61, operands in Q61
  function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = 128'(a) * 128'(b);
    return prod[124:61];
  endfunction

  // quarter-wave cosine entry in Q0.15, taylor series evaluated at elaboration
  function automatic logic [ROM_W-1:0] cos_entry(input int unsigned i, input int unsigned ta);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        mask;
    logic [63:0]        v;
    logic signed [63:0] sum;
    mask = (64'd1 << ta) - 64'd1;
    x    = (HALF_PI_Q61 >> ta) * 64'(i) + (((HALF_PI_Q61 & mask) * 64'(i)) >> ta);
    x2   = mul_q61(x, x);
    term = 64'd1 << 61;
    sum  = signed'(term);
    for (int unsigned k = 1; k <= 24 && term != 64'd0; k++) begin
      term = mul_q61(term, x2) / 64'((2 * k - 1) * (2 * k));
      if (k[0]) sum = sum - signed'(term);
      else sum = sum + signed'(term);
    end
    if (sum < 0) sum = '0;
    v = 64'(sum) >> 46;
    if (v > 64'd32767) v = 64'd32767;
    return v[ROM_W-1:0];
  endfunction

endpackage

// ----- src/linear_chirp_sample_generator_core.sv -----
// Linear FM chirp source: every transfer on the input channel yields exactly one output
// transfer, amplitude times the quarter-wave table cosine of a phase accumulator whose step
// grows by a signed increment each sample. One item is taken per clock while in_stall is low;
// after the input transfer writes the queue, the item passes the table read, amplitude multiply
// and output registers before out_valid rises. The rate is set by the front accumulator adds,
// one phase, step and index update per clock while in_stall is low, and by the single table
// read port in the back. Output stall backs up into a four entry queue before input stall rises.
// The table is constant and needs no fill after reset.
module linear_chirp_sample_generator_core #(
  parameter int PHASE_BITS      = lcsg_pkg::PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = lcsg_pkg::TABLE_ADDR_BITS_DEF,
  parameter int COUNT_BITS      = lcsg_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [lcsg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lcsg_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_restart,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [lcsg_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                 out_active,
  output logic                                 out_last
);

  localparam int Q_W = TABLE_ADDR_BITS + $bits(lcsg_pkg::flags_t);

  logic [lcsg_pkg::AMP_W-1:0]   amplitude_r;
  logic [lcsg_pkg::STEP_W-1:0]  start_step_r, step_increment_r;
  logic [lcsg_pkg::COUNT_W-1:0] sample_count_r;

  logic                       push, pop, full, empty;
  logic [TABLE_ADDR_BITS-1:0] push_addr, rd_addr;
  lcsg_pkg::flags_t           push_flags, rd_flags;
  logic [Q_W-1:0]             rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r      <= '0;
      start_step_r     <= '0;
      step_increment_r <= '0;
      sample_count_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lcsg_pkg::REG_AMPLITUDE:      amplitude_r      <= cfg_wdata[lcsg_pkg::AMP_W-1:0];
        lcsg_pkg::REG_START_STEP:     start_step_r     <= cfg_wdata[lcsg_pkg::STEP_W-1:0];
        lcsg_pkg::REG_STEP_INCREMENT: step_increment_r <= cfg_wdata[lcsg_pkg::STEP_W-1:0];
        lcsg_pkg::REG_SAMPLE_COUNT:   sample_count_r   <= cfg_wdata[lcsg_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = full;

  lcsg_front #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_restart     (in_restart),
    .full           (full),
    .start_step     (start_step_r),
    .step_increment (step_increment_r),
    .sample_count   (sample_count_r),
    .push           (push),
    .push_addr      (push_addr),
    .push_flags     (push_flags)
  );

  lcsg_fifo #(
    .WIDTH (Q_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_addr, push_flags}),
    .pop       (pop),
    .pop_data  (rd_data),
    .full      (full),
    .empty     (empty)
  );

  assign rd_addr  = rd_data[Q_W-1 -: TABLE_ADDR_BITS];
  assign rd_flags = rd_data[$bits(lcsg_pkg::flags_t)-1:0];

  lcsg_back #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .rd_addr    (rd_addr),
    .rd_flags   (rd_flags),
    .pop        (pop),
    .amplitude  (amplitude_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .out_active (out_active),
    .out_last   (out_last)
  );

endmodule

// ----- src/lcsg_front.sv -----
module lcsg_front #(
  parameter int PHASE_BITS      = lcsg_pkg::PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = lcsg_pkg::TABLE_ADDR_BITS_DEF,
  parameter int COUNT_BITS      = lcsg_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_restart,
  input  logic                              full,
  input  logic [lcsg_pkg::STEP_W-1:0]       start_step,
  input  logic [lcsg_pkg::STEP_W-1:0]       step_increment,
  input  logic [lcsg_pkg::COUNT_W-1:0]      sample_count,
  output logic                              push,
  output logic [TABLE_ADDR_BITS-1:0]        push_addr,
  output lcsg_pkg::flags_t                  push_flags
);

  localparam int CMP_W = ((COUNT_BITS > lcsg_pkg::COUNT_W) ? COUNT_BITS
                                                           : lcsg_pkg::COUNT_W) + 1;
  localparam int EXT_W = PHASE_BITS + lcsg_pkg::STEP_W;

  logic [PHASE_BITS-1:0] acc_r, acc_nxt, step_r, step_nxt;
  logic [COUNT_BITS-1:0] idx_r, idx_nxt;
  logic                  run_r, run_nxt;

  logic [PHASE_BITS-1:0] acc_c, step_c;
  logic [COUNT_BITS-1:0] idx_c;
  logic                  run_c;
  logic                  fin;
  logic [1:0]            quad;
  logic [TABLE_ADDR_BITS-1:0] taddr;
  logic [EXT_W-1:0]      start_ext;
  logic signed [EXT_W-1:0] inc_ext;
  logic [PHASE_BITS-1:0] start_al, inc_al;

  // scale the 32-bit step registers to the phase width (floor on right shift)
  assign start_ext = {start_step, {PHASE_BITS{1'b0}}};
  assign inc_ext   = signed'({step_increment, {PHASE_BITS{1'b0}}});
  assign start_al  = start_ext[EXT_W-1 -: PHASE_BITS];
  assign inc_al    = inc_ext[EXT_W-1 -: PHASE_BITS];

  assign push = in_valid && !full;

  always_comb begin
    acc_c  = acc_r;
    step_c = step_r;
    idx_c  = idx_r;
    run_c  = run_r;
    if (in_restart) begin
      acc_c  = '0;
      step_c = start_al;
      idx_c  = '0;
      run_c  = (sample_count != '0);
    end
    fin   = (CMP_W'(idx_c) + CMP_W'(1)) >= CMP_W'(sample_count);
    quad  = acc_c[PHASE_BITS-1 -: 2];
    taddr = acc_c[PHASE_BITS-3 -: TABLE_ADDR_BITS];

    push_flags.active = run_c;
    push_flags.last   = run_c && fin;
    push_flags.neg    = (quad == lcsg_pkg::QUAD_Q1) || (quad == lcsg_pkg::QUAD_Q2);
    // odd quadrants at table address zero sit exactly on a zero crossing
    push_flags.zero   = ((quad == lcsg_pkg::QUAD_Q1) || (quad == lcsg_pkg::QUAD_Q3))
                        && (taddr == '0);
    push_addr = ((quad == lcsg_pkg::QUAD_Q1) || (quad == lcsg_pkg::QUAD_Q3))
                ? ('0 - taddr) : taddr;

    acc_nxt  = acc_c;
    step_nxt = step_c;
    idx_nxt  = idx_c;
    run_nxt  = run_c;
    if (run_c) begin
      acc_nxt  = acc_c + step_c;
      step_nxt = step_c + inc_al;
      idx_nxt  = idx_c + COUNT_BITS'(1);
      run_nxt  = !fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      step_r <= '0;
      idx_r  <= '0;
      run_r  <= 1'b0;
    end else if (push) begin
      acc_r  <= acc_nxt;
      step_r <= step_nxt;
      idx_r  <= idx_nxt;
      run_r  <= run_nxt;
    end
  end

`include "linear_chirp_sample_generator_core_assert.svh"

  `LCSG_ASSERT_SAME(a_last_active, push && push_flags.last, push_flags.active, "idle last")
  `LCSG_ASSERT_NEXT(a_last_ends_sweep, push && push_flags.last, !run_r, "sweep runs after last")

endmodule

// ----- src/lcsg_fifo.sv -----
module lcsg_fifo #(
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int DEPTH = lcsg_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      count_r <= count_nxt;
    end
  end

`include "linear_chirp_sample_generator_core_assert.svh"

  `LCSG_ASSERT_SAME(a_no_pop_empty, pop, !empty, "pop from empty queue")
  `LCSG_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + CNT_W'(1), "count stuck")

endmodule

// ----- src/lcsg_back.sv -----
module lcsg_back #(
  parameter int TABLE_ADDR_BITS = lcsg_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                empty,
  input  logic [TABLE_ADDR_BITS-1:0]          rd_addr,
  input  lcsg_pkg::flags_t                    rd_flags,
  output logic                                pop,
  input  logic [lcsg_pkg::AMP_W-1:0]          amplitude,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lcsg_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                out_active,
  output logic                                out_last
);

  localparam int TBL_SIZE = 1 << TABLE_ADDR_BITS;
  localparam int RW       = lcsg_pkg::ROM_W;
  localparam int ROM_BITS = TBL_SIZE * RW;
  localparam int PROD_W   = lcsg_pkg::AMP_W + RW;

  function automatic logic [ROM_BITS-1:0] build_rom();
    logic [ROM_BITS-1:0] img;
    img = '0;
    for (int i = 0; i < TBL_SIZE; i++) begin
      img[i*RW +: RW] = lcsg_pkg::cos_entry(i, TABLE_ADDR_BITS);
    end
    return img;
  endfunction

  localparam logic [ROM_BITS-1:0] ROM_IMAGE = build_rom();

  logic                 adv;
  logic                 v1_r, v2_r, out_valid_r;
  logic [RW-1:0]        rom_q_r;
  lcsg_pkg::flags_t     flags1_r, flags2_r;
  logic [PROD_W-1:0]    prod_r;
  logic [RW-1:0]        mag;
  logic signed [lcsg_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                 active_r, last_r;

  // whole pipe moves together whenever the output slot frees up
  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && !empty;
  assign mag = prod_r[PROD_W-1 -: RW];

  always_comb begin
    sample_nxt = '0;
    if (flags2_r.active) begin
      sample_nxt = flags2_r.neg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rom_q_r  <= ROM_IMAGE[rd_addr*RW +: RW];
      flags1_r <= rd_flags;
      prod_r   <= PROD_W'(amplitude) * PROD_W'(flags1_r.zero ? '0 : rom_q_r);
      flags2_r <= flags1_r;
      sample_r <= sample_nxt;
      active_r <= flags2_r.active;
      last_r   <= flags2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= pop;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = sample_r;
  assign out_active = active_r;
  assign out_last   = last_r;

`include "linear_chirp_sample_generator_core_assert.svh"

  `LCSG_ASSERT_SAME(a_idle_zero, out_valid_r && !active_r, sample_r == '0 && !last_r, "bad idle")
  `LCSG_ASSERT_NEXT(a_pipe_holds, !adv, v1_r == $past(v1_r) && v2_r == $past(v2_r), "pipe moved")

endmodule
